// ===== sv/slcp_pkg.sv =====
// Shared types and constants for the sound log command parser.
package slcp_pkg;

    // Count bytes that contribute bits to a wait count
    localparam int MAX_COUNT_BYTES = 4;
    localparam int ACC_W           = 7 * MAX_COUNT_BYTES;
    localparam int SHIFT_W         = $clog2(MAX_COUNT_BYTES + 1);
    localparam int WAIT_W          = 29;
    localparam int OFFSET_W        = 32;
    localparam int BYTE_W          = 8;

    localparam logic [63:0] FIELD_MAX = 64'h1FFF_FFFF;
    localparam logic [63:0] CAP_RAW   = (ACC_W >= 29) ? FIELD_MAX
                                        : ((64'd1 << ACC_W) + 64'd1);
    localparam logic [63:0] CAP_64    = (CAP_RAW > FIELD_MAX) ? FIELD_MAX : CAP_RAW;
    localparam logic [WAIT_W-1:0] WAIT_CAP = CAP_64[WAIT_W-1:0];

    // Command bytes
    localparam logic [BYTE_W-1:0] CMD_SYNC  = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_NSYNC = 8'hFE;
    localparam logic [BYTE_W-1:0] CMD_END   = 8'hFD;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ADDR  = 2'd1,
        PH_DATA  = 2'd2,
        PH_COUNT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_WAIT  = 2'd1,
        KIND_LOOP  = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

endpackage

// ===== sv/sound_log_command_parser_core.sv =====
// Top level: byte-wise command decoder for a sound-chip register log.
// A result is registered and appears on the output in the cycle after the byte that completes it.
// Throughput: one stream byte per cycle; the single result register is reloaded in the
// same cycle it is taken, so input ready only drops while a result waits unclaimed.
// Reset (synchronous, active low) returns the phase to idle, clears the count state,
// clears loop_offset and drops any pending result or partial command.
module sound_log_command_parser_core
    import slcp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [OFFSET_W-1:0] i_cfg_wdata,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [BYTE_W-1:0]   i_stream_byte,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_kind,
    output logic [BYTE_W-1:0]   o_device_number,
    output logic [BYTE_W-1:0]   o_reg_address,
    output logic [BYTE_W-1:0]   o_reg_value,
    output logic [WAIT_W-1:0]   o_wait_ticks,
    output logic [OFFSET_W-1:0] o_restart_offset
);

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    t_phase               r_phase, n_phase;
    logic [OFFSET_W-1:0]  r_loop_offset;
    logic [BYTE_W-1:0]    r_held_device, n_held_device;
    logic [BYTE_W-1:0]    r_held_address, n_held_address;
    logic [ACC_W-1:0]     r_count_acc, n_count_acc;
    logic [SHIFT_W-1:0]   r_count_shift, n_count_shift;
    logic                 r_count_ovf, n_count_ovf;

    // Result register (output stage)
    logic                 r_out_valid;
    t_kind                r_kind, n_kind;
    logic [BYTE_W-1:0]    r_device, n_device;
    logic [BYTE_W-1:0]    r_address, n_address;
    logic [BYTE_W-1:0]    r_value, n_value;
    logic [WAIT_W-1:0]    r_wait, n_wait;
    logic [OFFSET_W-1:0]  r_offset, n_offset;
    logic                 n_has_result;

    logic                 accept;
    logic [ACC_W:0]       count_plus2;
    logic [63:0]          count_plus2_64;

    // Accept while the result stage is empty or is being drained this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Next phase
    // ------------------------------------------------------------------
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_stream_byte == CMD_NSYNC) begin
                    n_phase = PH_COUNT;
                end else if (i_stream_byte != CMD_SYNC && i_stream_byte != CMD_END) begin
                    n_phase = PH_ADDR;
                end
            end
            PH_ADDR:  n_phase = PH_DATA;
            PH_DATA:  n_phase = PH_IDLE;
            PH_COUNT: begin
                // Continuation bit keeps the count open
                if (!i_stream_byte[7]) begin
                    n_phase = PH_IDLE;
                end
            end
            default:  n_phase = PH_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Held fields, count state and result
    // ------------------------------------------------------------------
    always_comb begin
        n_held_device  = r_held_device;
        n_held_address = r_held_address;
        n_count_acc    = r_count_acc;
        n_count_shift  = r_count_shift;
        n_count_ovf    = r_count_ovf;
        n_has_result   = 1'b0;
        n_kind         = KIND_WRITE;
        n_device       = '0;
        n_address      = '0;
        n_value        = '0;
        n_wait         = '0;
        n_offset       = '0;
        count_plus2    = '0;
        count_plus2_64 = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_stream_byte == CMD_SYNC) begin
                    n_has_result = 1'b1;
                    n_kind       = KIND_WAIT;
                    n_wait       = WAIT_W'(1);
                end else if (i_stream_byte == CMD_NSYNC) begin
                    n_count_acc   = '0;
                    n_count_shift = '0;
                    n_count_ovf   = 1'b0;
                end else if (i_stream_byte == CMD_END) begin
                    n_has_result = 1'b1;
                    if (r_loop_offset != '0) begin
                        n_kind   = KIND_LOOP;
                        n_offset = r_loop_offset;
                    end else begin
                        n_kind   = KIND_END;
                    end
                end else begin
                    n_held_device = i_stream_byte;
                end
            end
            PH_ADDR: begin
                n_held_address = i_stream_byte;
            end
            PH_DATA: begin
                n_has_result = 1'b1;
                n_kind       = KIND_WRITE;
                n_device     = r_held_device;
                n_address    = r_held_address;
                n_value      = i_stream_byte;
            end
            PH_COUNT: begin
                if (r_count_shift < SHIFT_W'(MAX_COUNT_BYTES)) begin
                    // Drop the seven payload bits into the slot picked by the byte count
                    for (int k = 0; k < MAX_COUNT_BYTES; k++) begin
                        if (r_count_shift == SHIFT_W'(k)) begin
                            n_count_acc[7*k +: 7] = i_stream_byte[6:0];
                        end
                    end
                    n_count_shift = r_count_shift + SHIFT_W'(1);
                end else begin
                    n_count_ovf = 1'b1;
                end
                // Wait value from the completed count: accumulator plus two, clamped
                // to the cap. The accumulator already holds this byte's bits.
                count_plus2    = {1'b0, n_count_acc} + (ACC_W+1)'(2);
                count_plus2_64 = 64'(count_plus2);
                if (!i_stream_byte[7]) begin
                    n_has_result = 1'b1;
                    n_kind       = KIND_WAIT;
                    if (n_count_ovf || (count_plus2_64 > CAP_64)) begin
                        n_wait = WAIT_CAP;
                    end else begin
                        n_wait = count_plus2_64[WAIT_W-1:0];
                    end
                end
            end
            default: begin
                n_has_result = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_loop_offset  <= '0;
            r_held_device  <= '0;
            r_held_address <= '0;
            r_count_acc    <= '0;
            r_count_shift  <= '0;
            r_count_ovf    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_loop_offset <= i_cfg_wdata;
            end
            if (accept) begin
                r_phase        <= n_phase;
                r_held_device  <= n_held_device;
                r_held_address <= n_held_address;
                r_count_acc    <= n_count_acc;
                r_count_shift  <= n_count_shift;
                r_count_ovf    <= n_count_ovf;
                r_out_valid    <= n_has_result;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // Result payload: load only when a new result is produced
    always_ff @(posedge i_clk) begin
        if (accept && n_has_result) begin
            r_kind    <= n_kind;
            r_device  <= n_device;
            r_address <= n_address;
            r_value   <= n_value;
            r_wait    <= n_wait;
            r_offset  <= n_offset;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_device_number  = r_device;
    assign o_reg_address    = r_address;
    assign o_reg_value      = r_value;
    assign o_wait_ticks     = r_wait;
    assign o_restart_offset = r_offset;

`ifndef SYNTHESIS
    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_shift <= SHIFT_W'(MAX_COUNT_BYTES))
        else $error("count byte index beyond limit");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_ovf |-> (r_count_shift == SHIFT_W'(MAX_COUNT_BYTES)))
        else $error("count overflow before all count bytes taken");

    a_wait_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_WAIT) |-> (r_wait != '0 && r_wait <= WAIT_CAP))
        else $error("wait result out of range");

    a_nonwrite_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != KIND_WRITE) |->
            (r_device == '0 && r_address == '0 && r_value == '0))
        else $error("write fields set on non-write result");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_kind)))
        else $error("pending result lost or altered");
`endif

endmodule
